### rtl/core/mctf_pkg.sv
package mctf_pkg;

  // command codes of the command channel
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_UPDATE_WEIGHT  = 2'd0;
  localparam logic [1:0] CFG_ANALYSIS_MODE  = 2'd1;
  localparam logic [1:0] CFG_PICTURE_HEIGHT = 2'd2;
  localparam logic [1:0] CFG_PICTURE_WIDTH  = 2'd3;

  // field widths fixed by the interface
  localparam int unsigned PIX_W    = 16;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned DIM_W    = 9;
  localparam int unsigned MV_W     = 10;
  localparam int unsigned WEIGHT_W = 10;
  localparam int unsigned COMP_W   = 2;
  localparam int unsigned CFG_W    = 10;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned PROD_W   = PIX_W + WEIGHT_W + 1;
  localparam int unsigned NUM_W    = PROD_W + 1;

  // reset values of the configuration registers
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 10'd64;
  localparam logic [DIM_W-1:0]    DIM_RST    = 9'd256;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture the accepted command
    logic wr_en;     // store the written pixel
    logic rd_en;     // fetch the addressed pixel
    logic upd_addr;  // register clamped addresses and weighted residue
    logic upd_rd;    // fetch both reference pixels
    logic upd_wr;    // write back both updated pixels
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] cmd;
    logic       comp_ok;
    logic       pos_ok;
  } dp_status_t;

endpackage

### rtl/core/mctf_ctrl.sv
module mctf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  output logic                   done_o,
  input  mctf_pkg::dp_status_t   status_i,
  output mctf_pkg::ctrl_cmd_t    cmd_o
);
  import mctf_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_RESP   = 3'd2;
  localparam logic [2:0] ST_UPD_RD = 3'd3;
  localparam logic [2:0] ST_UPD_WR = 3'd4;

  logic [2:0] state_q, state_d;

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (status_i.cmd)
          CMD_WRITE: begin
            cmd_o.wr_en = status_i.comp_ok & status_i.pos_ok;
            state_d     = ST_IDLE;
          end
          CMD_UPDATE: begin
            cmd_o.upd_addr = status_i.comp_ok;
            state_d        = status_i.comp_ok ? ST_UPD_RD : ST_IDLE;
          end
          CMD_READ: begin
            cmd_o.rd_en = 1'b1;
            state_d     = ST_RESP;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_RESP: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_UPD_RD: begin
        cmd_o.upd_rd = 1'b1;
        state_d      = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        cmd_o.upd_wr = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/mctf_datapath.sv
module mctf_datapath #(
  parameter int unsigned MAX_WIDTH      = 256,
  parameter int unsigned MAX_HEIGHT     = 256,
  parameter int unsigned NUM_COMPONENTS = 3
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mctf_pkg::ctrl_cmd_t                cmd_i,
  output mctf_pkg::dp_status_t               status_o,
  // configuration
  input  logic                               cfg_valid_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [mctf_pkg::CFG_W-1:0]         cfg_data_i,
  // command payload
  input  logic [1:0]                         command_i,
  input  logic                               ref_select_i,
  input  logic [mctf_pkg::COMP_W-1:0]        component_i,
  input  logic [mctf_pkg::POS_W-1:0]         pixel_row_i,
  input  logic [mctf_pkg::POS_W-1:0]         pixel_col_i,
  input  logic signed [mctf_pkg::PIX_W-1:0]  pixel_value_i,
  input  logic signed [mctf_pkg::PIX_W-1:0]  residue_i,
  input  logic signed [mctf_pkg::MV_W-1:0]   prev_mv_row_i,
  input  logic signed [mctf_pkg::MV_W-1:0]   prev_mv_col_i,
  input  logic signed [mctf_pkg::MV_W-1:0]   next_mv_row_i,
  input  logic signed [mctf_pkg::MV_W-1:0]   next_mv_col_i,
  output logic signed [mctf_pkg::PIX_W-1:0]  read_value_o
);
  import mctf_pkg::*;

  localparam int unsigned PLANE = MAX_HEIGHT * MAX_WIDTH;
  localparam int unsigned DEPTH = NUM_COMPONENTS * PLANE;
  localparam int unsigned AW    = $clog2(DEPTH);

  // configuration registers
  logic [WEIGHT_W-1:0] weight_q;
  logic                analysis_q;
  logic [DIM_W-1:0]    height_q;
  logic [DIM_W-1:0]    width_q;

  // captured command
  logic [1:0]              cmd_q;
  logic                    sel_q;
  logic [COMP_W-1:0]       comp_q;
  logic [POS_W-1:0]        row_q;
  logic [POS_W-1:0]        col_q;
  logic [PIX_W-1:0]        pixel_q;
  logic signed [PIX_W-1:0] residue_q;
  logic signed [MV_W-1:0]  pmv_row_q;
  logic signed [MV_W-1:0]  pmv_col_q;
  logic signed [MV_W-1:0]  nmv_row_q;
  logic signed [MV_W-1:0]  nmv_col_q;

  // update intermediates
  logic [AW-1:0]            prev_addr_q;
  logic [AW-1:0]            next_addr_q;
  logic signed [PROD_W-1:0] prod_q;

  // reference stores
  logic [PIX_W-1:0] prev_mem [DEPTH];
  logic [PIX_W-1:0] next_mem [DEPTH];
  logic [PIX_W-1:0] prev_rdata_q;
  logic [PIX_W-1:0] next_rdata_q;

  logic             comp_ok;
  logic             pos_ok;
  logic             acc_ok_q;
  logic [AW-1:0]    acc_addr;
  logic [DIM_W-1:0] eff_h;
  logic [DIM_W-1:0] eff_w;

  logic             prev_we, next_we, prev_re, next_re;
  logic [AW-1:0]    prev_waddr, next_waddr, prev_raddr, next_raddr;
  logic [PIX_W-1:0] prev_wdata, next_wdata;

  function automatic logic [AW-1:0] addr_of(logic [COMP_W-1:0] c, logic [DIM_W-1:0] r,
                                            logic [DIM_W-1:0] k);
    addr_of = AW'(c) * AW'(PLANE) + AW'(r) * AW'(MAX_WIDTH) + AW'(k);
  endfunction

  // saturate a picture size into 1 to maxv
  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] d, int unsigned maxv);
    logic [DIM_W-1:0] res;
    if (d == '0) begin
      res = DIM_W'(1);
    end else if (32'(d) > maxv) begin
      res = DIM_W'(maxv);
    end else begin
      res = d;
    end
    return res;
  endfunction

  // displace a coordinate and keep it inside 0 to dim-1
  function automatic logic [DIM_W-1:0] clamp_pos(logic [POS_W-1:0] p, logic signed [MV_W-1:0] mv,
                                                 logic [DIM_W-1:0] dim);
    logic signed [MV_W:0] pos;
    logic [DIM_W-1:0]     res;
    pos = $signed({3'b000, p}) + $signed({mv[MV_W-1], mv});
    if (pos < 0) begin
      res = '0;
    end else if (pos >= $signed({2'b00, dim})) begin
      res = dim - DIM_W'(1);
    end else begin
      res = pos[DIM_W-1:0];
    end
    return res;
  endfunction

  // ref*256 -/+ weighted residue, rounded half away from zero, wrapped to 16 bits
  function automatic logic [PIX_W-1:0] lift(logic [PIX_W-1:0] ref_v,
                                            logic signed [PROD_W-1:0] prod, logic add);
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] sum;
    if (add) begin
      num = $signed({{(NUM_W-PIX_W-FRAC_W){ref_v[PIX_W-1]}}, ref_v, {FRAC_W{1'b0}}})
          + $signed({prod[PROD_W-1], prod});
    end else begin
      num = $signed({{(NUM_W-PIX_W-FRAC_W){ref_v[PIX_W-1]}}, ref_v, {FRAC_W{1'b0}}})
          - $signed({prod[PROD_W-1], prod});
    end
    sum = num + (num[NUM_W-1] ? NUM_W'(127) : NUM_W'(128));
    return sum[FRAC_W +: PIX_W];
  endfunction

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q   <= WEIGHT_RST;
      analysis_q <= 1'b0;
      height_q   <= DIM_RST;
      width_q    <= DIM_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_UPDATE_WEIGHT:  weight_q   <= cfg_data_i[WEIGHT_W-1:0];
        CFG_ANALYSIS_MODE:  analysis_q <= cfg_data_i[0];
        CFG_PICTURE_HEIGHT: height_q   <= cfg_data_i[DIM_W-1:0];
        CFG_PICTURE_WIDTH:  width_q    <= cfg_data_i[DIM_W-1:0];
        default:            weight_q   <= weight_q;
      endcase
    end
  end

  // capture of an accepted command
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q     <= command_i;
      sel_q     <= ref_select_i;
      comp_q    <= component_i;
      row_q     <= pixel_row_i;
      col_q     <= pixel_col_i;
      pixel_q   <= pixel_value_i;
      residue_q <= residue_i;
      pmv_row_q <= prev_mv_row_i;
      pmv_col_q <= prev_mv_col_i;
      nmv_row_q <= next_mv_row_i;
      nmv_col_q <= next_mv_col_i;
    end
  end

  // decode of the captured command
  assign comp_ok  = 32'(comp_q) < NUM_COMPONENTS;
  assign pos_ok   = (32'(row_q) < MAX_HEIGHT) && (32'(col_q) < MAX_WIDTH);
  assign acc_addr = addr_of(comp_q, DIM_W'(row_q), DIM_W'(col_q));
  assign eff_h    = eff_dim(height_q, MAX_HEIGHT);
  assign eff_w    = eff_dim(width_q, MAX_WIDTH);

  assign status_o.cmd     = cmd_q;
  assign status_o.comp_ok = comp_ok;
  assign status_o.pos_ok  = pos_ok;

  // clamped addresses and weighted residue for an update
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_addr) begin
      prev_addr_q <= addr_of(comp_q, clamp_pos(row_q, pmv_row_q, eff_h),
                             clamp_pos(col_q, pmv_col_q, eff_w));
      next_addr_q <= addr_of(comp_q, clamp_pos(row_q, nmv_row_q, eff_h),
                             clamp_pos(col_q, nmv_col_q, eff_w));
      prod_q      <= residue_q * $signed({1'b0, weight_q});
    end
  end

  // memory port selection
  always_comb begin
    prev_we    = cmd_i.upd_wr | (cmd_i.wr_en & ~sel_q);
    next_we    = cmd_i.upd_wr | (cmd_i.wr_en & sel_q);
    prev_re    = cmd_i.upd_rd | (cmd_i.rd_en & ~sel_q);
    next_re    = cmd_i.upd_rd | (cmd_i.rd_en & sel_q);
    prev_waddr = cmd_i.wr_en ? acc_addr : prev_addr_q;
    next_waddr = cmd_i.wr_en ? acc_addr : next_addr_q;
    prev_raddr = cmd_i.rd_en ? acc_addr : prev_addr_q;
    next_raddr = cmd_i.rd_en ? acc_addr : next_addr_q;
    prev_wdata = cmd_i.wr_en ? pixel_q : lift(prev_rdata_q, prod_q, analysis_q);
    next_wdata = cmd_i.wr_en ? pixel_q : lift(next_rdata_q, prod_q, analysis_q);
  end

  // previous reference store
  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (prev_re) begin
      prev_rdata_q <= prev_mem[prev_raddr];
    end
  end

  // next reference store
  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (next_re) begin
      next_rdata_q <= next_mem[next_raddr];
    end
  end

  // read response, zero for an access outside the stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      acc_ok_q <= comp_ok & pos_ok;
    end
  end

  assign read_value_o = !acc_ok_q ? '0 : (sel_q ? $signed(next_rdata_q) : $signed(prev_rdata_q));

endmodule

### rtl/core/mctf_motion_compensated_update.sv
// Motion-compensated update step of a 5/3 temporal lifting filter.
// Holds a previous and a next reference picture of NUM_COMPONENTS planes.
// Command channel: a command is taken at a rising edge with start high and
// busy low; busy stays high until the block can take the next one.
//   write  - stores pixel_value into the selected reference
//   read   - returns the stored pixel on read_value_o with done_o high for
//            one cycle, zero for a position outside the stores
//   update - read-modify-write of both references at the positions given by
//            the motion vectors, clamped into the picture
// Each store has a single registered read port, and the residue-by-weight
// product is registered before the write back.
// Configuration channel: cfg_valid_i with cfg_ready_o always high, register
// index on cfg_index_i and data on cfg_data_i; write only while not busy.
// Reset returns the controller to idle and the registers to weight one
// quarter, synthesis direction and full picture size; picture contents are
// not cleared. The receiver cannot stall: each read result is shown once.
module mctf_motion_compensated_update #(
  parameter int unsigned MAX_WIDTH      = 256,
  parameter int unsigned MAX_HEIGHT     = 256,
  parameter int unsigned NUM_COMPONENTS = 3
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // command channel
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         command_i,
  input  logic                               ref_select_i,
  input  logic [mctf_pkg::COMP_W-1:0]        component_i,
  input  logic [mctf_pkg::POS_W-1:0]         pixel_row_i,
  input  logic [mctf_pkg::POS_W-1:0]         pixel_col_i,
  input  logic signed [mctf_pkg::PIX_W-1:0]  pixel_value_i,
  input  logic signed [mctf_pkg::PIX_W-1:0]  residue_i,
  input  logic signed [mctf_pkg::MV_W-1:0]   prev_mv_row_i,
  input  logic signed [mctf_pkg::MV_W-1:0]   prev_mv_col_i,
  input  logic signed [mctf_pkg::MV_W-1:0]   next_mv_row_i,
  input  logic signed [mctf_pkg::MV_W-1:0]   next_mv_col_i,
  // result
  output logic                               done_o,
  output logic signed [mctf_pkg::PIX_W-1:0]  read_value_o,
  // configuration channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [1:0]                         cfg_index_i,
  input  logic [mctf_pkg::CFG_W-1:0]         cfg_data_i
);
  import mctf_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  // sequencing of each transaction
  mctf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .status_i (dp_status),
    .cmd_o    (ctrl_cmd)
  );

  // stores, address clamping and lifting arithmetic
  mctf_datapath #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .NUM_COMPONENTS (NUM_COMPONENTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .status_o      (dp_status),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .command_i     (command_i),
    .ref_select_i  (ref_select_i),
    .component_i   (component_i),
    .pixel_row_i   (pixel_row_i),
    .pixel_col_i   (pixel_col_i),
    .pixel_value_i (pixel_value_i),
    .residue_i     (residue_i),
    .prev_mv_row_i (prev_mv_row_i),
    .prev_mv_col_i (prev_mv_col_i),
    .next_mv_row_i (next_mv_row_i),
    .next_mv_col_i (next_mv_col_i),
    .read_value_o  (read_value_o)
  );

endmodule
